[rtl/core/ttt_pkg.sv]
`default_nettype none

package ttt_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int SLOT_IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  // the slot field is 4 bits wide, so at most sixteen slots take part in a scan
  localparam int SCAN_N      = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;

  localparam int MODE_W = 2;
  localparam int SLOT_W = 4;
  localparam int DUR_W  = 32;
  localparam int CORE_W = 8;
  localparam int VEC_W  = 8;
  localparam int CNT_W  = 64;

  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ARM     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

  localparam int                CFG_ADDR_W      = 2;
  localparam logic [CFG_ADDR_W-1:0] ADDR_WAKE_VECTOR = 2'd0;
  localparam logic [VEC_W-1:0]  WAKE_VECTOR_RST = 8'd32;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_ARMED   = 2'd1,
    ST_PENDING = 2'd2
  } slot_st_t;

  typedef struct packed {
    logic [DUR_W-1:0]  duration;
    logic [CNT_W-1:0]  start;
    logic [CORE_W-1:0] core;
    logic              cb;
  } slot_ent_t;

  localparam int ENT_W = $bits(slot_ent_t);

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              action;
    logic [CORE_W-1:0] core;
    logic [VEC_W-1:0]  vector;
  } res_t;

  typedef struct packed {
    logic tick_start;
    logic arm;
    logic rel;
    logic step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic held_v;
    logic out_free;
    logic idx_last;
  } sts_t;

endpackage

`default_nettype wire

[rtl/core/ttt_ram.sv]
`default_nettype none

module ttt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                          wr_data,
  input  wire logic                                      rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/ttt_ctrl.sv]
`default_nettype none

module ttt_ctrl
  import ttt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [MODE_W-1:0] in_mode,
  output logic                   in_stall,
  input  wire sts_t              sts,
  output cmd_t                   cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;
  logic   step;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // a hit may only advance once the held result has somewhere to go
  assign step = (state_r == S_SCAN) && (!sts.hit || !sts.held_v || sts.out_free);

  always_comb begin
    cmd.tick_start = accept && (in_mode == MODE_TICK);
    cmd.arm        = accept && (in_mode == MODE_ARM);
    cmd.rel        = accept && (in_mode == MODE_RELEASE);
    cmd.step       = step;
    cmd.flush      = (state_r == S_FLUSH) && sts.held_v && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.tick_start) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (step && sts.idx_last) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!sts.held_v || sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_idle_no_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !sts.held_v)
    else $error("held result left behind when returning to idle");

  a_flush_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> (state_r == S_IDLE))
    else $error("flush did not end the tick");

  a_scan_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && ($past(state_r) == S_IDLE)) |-> $past(cmd.tick_start))
    else $error("scan started without a tick");

endmodule

`default_nettype wire

[rtl/core/ttt_dp.sv]
`default_nettype none

module ttt_dp
  import ttt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  input  wire logic [SLOT_W-1:0] in_slot,
  input  wire logic [DUR_W-1:0]  in_duration,
  input  wire logic [CORE_W-1:0] in_target_core,
  input  wire logic              in_run_callback,
  input  wire logic [VEC_W-1:0]  wake_vector,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic [SLOT_W-1:0]      out_expired_slot,
  output logic                   out_action,
  output logic [CORE_W-1:0]      out_wake_core,
  output logic [VEC_W-1:0]       out_vector,
  output logic                   out_last
);

  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [SLOT_IDX_W-1:0] idx_r, idx_nxt;
  slot_st_t              status_r [NUM_SLOTS];
  slot_st_t              status_nxt [NUM_SLOTS];
  logic                  held_v_r, held_v_nxt;
  res_t                  held_r, held_nxt;
  logic                  out_valid_r, out_valid_nxt;
  res_t                  out_r, out_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [SLOT_IDX_W-1:0] slot_ix;
  logic                  slot_ok;
  logic                  wr_en;
  slot_ent_t             wr_ent;
  logic                  rd_en;
  logic [SLOT_IDX_W-1:0] rd_addr;
  logic [ENT_W-1:0]      rd_data;
  slot_ent_t             ent;
  logic [CNT_W-1:0]      elapsed;
  logic                  hit;
  logic                  idx_last;
  logic                  out_free;
  res_t                  new_res;

  assign slot_ix = SLOT_IDX_W'(in_slot);
  assign slot_ok = (32'(in_slot) < 32'(NUM_SLOTS));

  assign wr_en  = cmd.arm && slot_ok;
  assign wr_ent = '{duration: in_duration, start: cnt_r, core: in_target_core,
                    cb: in_run_callback};

  assign idx_last = (idx_r == SLOT_IDX_W'(SCAN_N - 1));

  // prefetch the next slot while the current one is checked
  assign rd_en   = cmd.tick_start || (cmd.step && !idx_last);
  assign rd_addr = cmd.tick_start ? '0 : SLOT_IDX_W'(idx_r + SLOT_IDX_W'(1));

  ttt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_ix),
    .wr_data (wr_ent),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign ent     = slot_ent_t'(rd_data);
  assign elapsed = cnt_r - ent.start;
  assign hit     = (status_r[idx_r] == ST_ARMED) && (elapsed >= CNT_W'(ent.duration));

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    new_res.slot   = SLOT_W'(idx_r);
    new_res.action = ent.cb;
    new_res.core   = ent.cb ? '0 : ent.core;
    new_res.vector = ent.cb ? '0 : wake_vector;
  end

  always_comb begin
    sts.hit      = hit;
    sts.held_v   = held_v_r;
    sts.out_free = out_free;
    sts.idx_last = idx_last;
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    status_nxt    = status_r;
    held_v_nxt    = held_v_r;
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    out_last_nxt  = out_last_r;

    if (cmd.tick_start) begin
      // wrap from all ones straight to one
      cnt_nxt = (cnt_r == '1) ? CNT_W'(1) : cnt_r + CNT_W'(1);
      idx_nxt = '0;
    end
    if (wr_en) begin
      status_nxt[slot_ix] = (in_duration != '0) ? ST_ARMED : ST_FREE;
    end
    if (cmd.rel && slot_ok && (status_r[slot_ix] == ST_PENDING)) begin
      status_nxt[slot_ix] = ST_FREE;
    end
    if (cmd.step) begin
      if (!idx_last) begin
        idx_nxt = SLOT_IDX_W'(idx_r + SLOT_IDX_W'(1));
      end
      if (hit) begin
        status_nxt[idx_r] = ent.cb ? ST_PENDING : ST_FREE;
        // a later hit proves the held one is not the last beat
        if (held_v_r) begin
          out_valid_nxt = 1'b1;
          out_nxt       = held_r;
          out_last_nxt  = 1'b0;
        end
        held_nxt   = new_res;
        held_v_nxt = 1'b1;
      end
    end
    if (cmd.flush) begin
      out_valid_nxt = 1'b1;
      out_nxt       = held_r;
      out_last_nxt  = 1'b1;
      held_v_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      idx_r       <= '0;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        status_r[i] <= ST_FREE;
      end
    end else begin
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      held_v_r    <= held_v_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r     <= held_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_expired_slot = out_r.slot;
  assign out_action       = out_r.action;
  assign out_wake_core    = out_r.core;
  assign out_vector       = out_r.vector;
  assign out_last         = out_last_r;

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("slot RAM read and write in the same cycle");

  a_hit_leaves_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && hit) |=> (status_r[$past(idx_r)] != ST_ARMED))
    else $error("expired slot still armed");

  a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick_start |=> ((cnt_r != $past(cnt_r)) && (cnt_r != '0)))
    else $error("tick count did not advance");

endmodule

`default_nettype wire

[rtl/core/tick_timeout_table.sv]
`default_nettype none

// Channel  Direction  Handshake         Beat carries
// in_      input      in_valid/in_stall  mode, slot, duration, target_core, run_callback
// out_     output     out_valid/out_stall expired_slot, action, wake_core, vector, last
// cfg      input      APB psel/penable  wake_vector register at byte address 0
//
// Arm and release are each done in the cycle they are accepted. A tick reads and
// checks one slot of the slot RAM per cycle, while no expiry is held up by a full,
// stalled output register, then flushes the last held expiry. Such a stall holds the
// tick whenever an expiry, or the final flush, meets a held result.
// Reset (synchronous, rst_n low) clears the tick count, frees all slots and sets
// wake_vector to 32; slot contents in RAM stay as they were.

module tick_timeout_table
  import ttt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [MODE_W-1:0]     in_mode,
  input  wire logic [SLOT_W-1:0]     in_slot,
  input  wire logic [DUR_W-1:0]      in_duration,
  input  wire logic [CORE_W-1:0]     in_target_core,
  input  wire logic                  in_run_callback,

  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [SLOT_W-1:0]          out_expired_slot,
  output logic                       out_action,
  output logic [CORE_W-1:0]          out_wake_core,
  output logic [VEC_W-1:0]           out_vector,
  output logic                       out_last,

  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [VEC_W-1:0] wake_vector_r, wake_vector_nxt;
  logic             cfg_wr;
  cmd_t             cmd;
  sts_t             sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_WAKE_VECTOR);

  assign wake_vector_nxt = cfg_wr ? pwdata[VEC_W-1:0] : wake_vector_r;
  assign prdata = (paddr == ADDR_WAKE_VECTOR) ? 32'(wake_vector_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wake_vector_r <= WAKE_VECTOR_RST;
    end else begin
      wake_vector_r <= wake_vector_nxt;
    end
  end

  ttt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ttt_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_slot          (in_slot),
    .in_duration      (in_duration),
    .in_target_core   (in_target_core),
    .in_run_callback  (in_run_callback),
    .wake_vector      (wake_vector_r),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_expired_slot (out_expired_slot),
    .out_action       (out_action),
    .out_wake_core    (out_wake_core),
    .out_vector       (out_vector),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire
